FILE: hw/rtl/dsce_pkg.sv
// shared types and constants of the dot stuffing crlf encoder
package dsce_pkg;

    localparam logic [7:0] CH_LF  = 8'h0A;
    localparam logic [7:0] CH_CR  = 8'h0D;
    localparam logic [7:0] CH_DOT = 8'h2E;

    localparam int LIMIT_W         = 30;
    localparam int MAX_RESULTS     = 4;
    localparam int IDX_W           = $clog2(MAX_RESULTS);
    localparam int QUEUE_DEPTH_DEF = 2;

    typedef enum logic [0:0] {
        REG_LIMIT_ENABLE    = 1'b0,
        REG_BODY_LINE_LIMIT = 1'b1
    } reg_index_t;

    typedef struct packed {
        logic               limit_enable;
        logic [LIMIT_W-1:0] body_line_limit;
    } cfg_t;

    typedef struct packed {
        logic [MAX_RESULTS-1:0][7:0] byte_vec;
        logic [IDX_W-1:0]            last_idx;
        logic                        done;
    } cmd_t;

    typedef struct packed {
        logic at_line_start;
        logic stopped;
    } front_status_t;

endpackage

FILE: hw/rtl/dot_stuffing_crlf_encoder.sv
// top level of the dot stuffing crlf encoder
// Encodes a stored mail message for a multi-line reply: every LF leaves as CR LF, a dot that
// opens a line leaves doubled, and a message that ends inside a line gets a closing CR LF.
// With limit_enable set, the output stops after the header separator line plus
// body_line_limit body lines; later input words are taken and dropped until the message's
// last word. Each input word before a stop gives one to four output words, a dropped word
// gives none. The front takes one input word per cycle whenever the command queue
// (QUEUE_DEPTH entries) has room, and the back sends one output word per cycle while the
// queue holds a command and m_tready is high, so the sustained rate is set by the output
// port. No clearing pass follows reset. Write registers only while the block is idle.
module dot_stuffing_crlf_encoder
    import dsce_pkg::*;
#(
    parameter int QUEUE_DEPTH = QUEUE_DEPTH_DEF
) (
    input  logic               clk,
    input  logic               rst_n,
    input  logic               cfg_valid,
    output logic               cfg_ready,
    input  logic               cfg_index,
    input  logic [LIMIT_W-1:0] cfg_data,
    input  logic               s_tvalid,
    output logic               s_tready,
    input  logic [7:0]         s_tdata,  // data_byte
    input  logic               s_tlast,  // last_byte
    output logic               m_tvalid,
    input  logic               m_tready,
    output logic [7:0]         m_tdata,  // out_byte
    output logic               m_tlast,  // last_of_run
    output logic               m_tuser   // message_done
);

    cfg_t          cfg_reg;
    cfg_t          cfg_next;
    front_status_t front_st;
    cmd_t          push_cmd;
    cmd_t          head_cmd;
    logic          push;
    logic          pop;
    logic          not_empty;
    logic          not_full;
    logic          s_accept;

    assign cfg_ready = 1'b1;
    assign s_tready  = not_full;
    assign s_accept  = s_tvalid && s_tready;

    always_comb
    begin
        cfg_next = cfg_reg;
        if (cfg_valid)
        begin
            case (reg_index_t'(cfg_index))
                REG_LIMIT_ENABLE:    cfg_next.limit_enable    = cfg_data[0];
                REG_BODY_LINE_LIMIT: cfg_next.body_line_limit = cfg_data;
                default:             cfg_next = cfg_reg;
            endcase
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cfg_reg <= '0;
        end
        else
        begin
            cfg_reg <= cfg_next;
        end
    end

    dsce_front u_front (
        .clk       (clk),
        .rst_n     (rst_n),
        .cfg       (cfg_reg),
        .accept    (s_accept),
        .data_byte (s_tdata),
        .last_byte (s_tlast),
        .push      (push),
        .push_cmd  (push_cmd),
        .status    (front_st)
    );

    dsce_queue #(
        .DEPTH (QUEUE_DEPTH)
    ) u_queue (
        .clk       (clk),
        .rst_n     (rst_n),
        .push      (push),
        .push_cmd  (push_cmd),
        .pop       (pop),
        .head_cmd  (head_cmd),
        .not_empty (not_empty),
        .not_full  (not_full)
    );

    dsce_back u_back (
        .clk       (clk),
        .rst_n     (rst_n),
        .head_cmd  (head_cmd),
        .not_empty (not_empty),
        .pop       (pop),
        .m_tvalid  (m_tvalid),
        .m_tready  (m_tready),
        .m_tdata   (m_tdata),
        .m_tlast   (m_tlast),
        .m_tuser   (m_tuser)
    );

    // message end always closes the run of output words
    assert property (@(posedge clk) disable iff (!rst_n)
        m_tvalid && m_tuser |-> m_tlast)
        else $error("message_done without last_of_run");

    // the last word of a message returns the front to a fresh line, not stopped
    assert property (@(posedge clk) disable iff (!rst_n)
        s_accept && s_tlast |=> front_st.at_line_start && !front_st.stopped)
        else $error("front state not cleared after message end");

    // a stopped front never queues commands
    assert property (@(posedge clk) disable iff (!rst_n)
        front_st.stopped |-> !push)
        else $error("command queued while stopped");

endmodule

FILE: hw/rtl/dsce_queue.sv
// short command queue between the front and back parts
module dsce_queue
    import dsce_pkg::*;
#(
    parameter int DEPTH = QUEUE_DEPTH_DEF
) (
    input  logic clk,
    input  logic rst_n,
    input  logic push,
    input  cmd_t push_cmd,
    input  logic pop,
    output cmd_t head_cmd,
    output logic not_empty,
    output logic not_full
);

    localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1;

    cmd_t          entry_reg [DEPTH];
    logic [AW-1:0] wr_ptr_reg;
    logic [AW-1:0] wr_ptr_next;
    logic [AW-1:0] rd_ptr_reg;
    logic [AW-1:0] rd_ptr_next;
    logic [AW:0]   count_reg;
    logic [AW:0]   count_next;

    assign not_empty = (count_reg != '0);
    assign not_full  = (count_reg != (AW+1)'(DEPTH));
    assign head_cmd  = entry_reg[rd_ptr_reg];

    always_comb
    begin
        wr_ptr_next = wr_ptr_reg;
        rd_ptr_next = rd_ptr_reg;
        count_next  = count_reg;
        if (push)
        begin
            wr_ptr_next = (wr_ptr_reg == AW'(DEPTH - 1)) ? '0 : wr_ptr_reg + 1'b1;
        end
        if (pop)
        begin
            rd_ptr_next = (rd_ptr_reg == AW'(DEPTH - 1)) ? '0 : rd_ptr_reg + 1'b1;
        end
        if (push && !pop)
        begin
            count_next = count_reg + 1'b1;
        end
        else if (pop && !push)
        begin
            count_next = count_reg - 1'b1;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end
        else
        begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            count_reg  <= count_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (push)
        begin
            entry_reg[wr_ptr_reg] <= push_cmd;
        end
    end

endmodule

FILE: hw/rtl/dsce_front.sv
// front part: takes message bytes, tracks lines and builds output commands
module dsce_front
    import dsce_pkg::*;
(
    input  logic          clk,
    input  logic          rst_n,
    input  cfg_t          cfg,
    input  logic          accept,
    input  logic [7:0]    data_byte,
    input  logic          last_byte,
    output logic          push,
    output cmd_t          push_cmd,
    output front_status_t status
);

    logic               at_line_start_reg;
    logic               at_line_start_next;
    logic               in_body_reg;
    logic               in_body_next;
    logic [LIMIT_W-1:0] lines_left_reg;
    logic [LIMIT_W-1:0] lines_left_next;
    logic               stopped_reg;
    logic               stopped_next;

    logic               is_lf;
    logic               add_dot;
    logic               stop_now;
    logic [LIMIT_W-1:0] lines_dec;

    assign status.at_line_start = at_line_start_reg;
    assign status.stopped       = stopped_reg;

    assign is_lf     = (data_byte == CH_LF);
    assign add_dot   = (data_byte == CH_DOT) && at_line_start_reg;
    assign lines_dec = (lines_left_reg != '0) ? lines_left_reg - 1'b1 : '0;

    // line counting and stop decision
    always_comb
    begin
        in_body_next    = in_body_reg;
        lines_left_next = lines_left_reg;
        stop_now        = 1'b0;
        if (is_lf)
        begin
            if (!in_body_reg)
            begin
                if (at_line_start_reg)
                begin
                    in_body_next    = 1'b1;
                    lines_left_next = cfg.body_line_limit;
                    stop_now        = cfg.limit_enable && (cfg.body_line_limit == '0);
                end
            end
            else if (cfg.limit_enable)
            begin
                lines_left_next = lines_dec;
                stop_now        = (lines_dec == '0);
            end
        end
    end

    // command for the back part
    always_comb
    begin
        push_cmd.byte_vec = '0;
        push_cmd.last_idx = '0;
        push_cmd.done     = stop_now || last_byte;
        if (is_lf)
        begin
            push_cmd.byte_vec[0] = CH_CR;
            push_cmd.byte_vec[1] = CH_LF;
            push_cmd.last_idx    = IDX_W'(1);
        end
        else if (add_dot)
        begin
            push_cmd.byte_vec[0] = CH_DOT;
            push_cmd.byte_vec[1] = data_byte;
            push_cmd.byte_vec[2] = CH_CR;
            push_cmd.byte_vec[3] = CH_LF;
            push_cmd.last_idx    = last_byte ? IDX_W'(3) : IDX_W'(1);
        end
        else
        begin
            push_cmd.byte_vec[0] = data_byte;
            push_cmd.byte_vec[1] = CH_CR;
            push_cmd.byte_vec[2] = CH_LF;
            push_cmd.last_idx    = last_byte ? IDX_W'(2) : IDX_W'(0);
        end
    end

    assign push = accept && !stopped_reg;

    always_comb
    begin
        at_line_start_next = at_line_start_reg;
        stopped_next       = stopped_reg;
        if (accept)
        begin
            if (last_byte)
            begin
                at_line_start_next = 1'b1;
                stopped_next       = 1'b0;
            end
            else if (!stopped_reg)
            begin
                at_line_start_next = is_lf;
                stopped_next       = stop_now;
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            at_line_start_reg <= 1'b1;
            in_body_reg       <= 1'b0;
            lines_left_reg    <= '0;
            stopped_reg       <= 1'b0;
        end
        else
        begin
            at_line_start_reg <= at_line_start_next;
            stopped_reg       <= stopped_next;
            if (accept && (last_byte || !stopped_reg))
            begin
                in_body_reg    <= last_byte ? 1'b0 : in_body_next;
                lines_left_reg <= last_byte ? '0 : lines_left_next;
            end
        end
    end

endmodule

FILE: hw/rtl/dsce_back.sv
// back part: steps through the bytes of each queued command
module dsce_back
    import dsce_pkg::*;
(
    input  logic       clk,
    input  logic       rst_n,
    input  cmd_t       head_cmd,
    input  logic       not_empty,
    output logic       pop,
    output logic       m_tvalid,
    input  logic       m_tready,
    output logic [7:0] m_tdata,
    output logic       m_tlast,
    output logic       m_tuser
);

    logic [IDX_W-1:0] idx_reg;
    logic [IDX_W-1:0] idx_next;
    logic             at_end;

    assign at_end   = (idx_reg == head_cmd.last_idx);
    assign m_tvalid = not_empty;
    assign m_tdata  = head_cmd.byte_vec[idx_reg];
    assign m_tlast  = at_end;
    assign m_tuser  = at_end && head_cmd.done;
    assign pop      = not_empty && m_tready && at_end;

    always_comb
    begin
        idx_next = idx_reg;
        if (not_empty && m_tready)
        begin
            idx_next = at_end ? '0 : idx_reg + 1'b1;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            idx_reg <= '0;
        end
        else
        begin
            idx_reg <= idx_next;
        end
    end

endmodule

FILE: tb/sv/dot_stuffing_crlf_encoder_tb.sv
// testbench for the dot stuffing crlf encoder: random stream traffic checked against a predictor
`timescale 1ns / 100ps

module dot_stuffing_crlf_encoder_tb
    import dsce_pkg::*;
;

    typedef struct packed {
        logic [7:0] data;
        logic       last;
    } raw_byte_t;

    typedef struct packed {
        logic [7:0] byte_val;
        logic       run_end;
        logic       msg_done;
    } enc_word_t;

    logic               clk = 1'b0;
    logic               rst_n = 1'b0;
    logic               cfg_valid = 1'b0;
    logic               cfg_ready;
    logic               cfg_index = 1'b0;
    logic [LIMIT_W-1:0] cfg_data = '0;
    logic               s_tvalid = 1'b0;
    logic               s_tready;
    logic [7:0]         s_tdata = '0;  // data_byte
    logic               s_tlast = 1'b0;  // last_byte
    logic               m_tvalid;
    logic               m_tready = 1'b0;
    logic [7:0]         m_tdata;  // out_byte
    logic               m_tlast;  // last_of_run
    logic               m_tuser;  // message_done

    raw_byte_t pending[$];
    enc_word_t expected_words[$];

    logic               cfg_enable = 1'b0;
    logic [LIMIT_W-1:0] cfg_limit = '0;
    logic               line_start = 1'b1;
    logic               body_seen = 1'b0;
    logic [30:0]        lines_remaining = '0;
    logic               msg_stopped = 1'b0;

    int        fail_count = 0;
    int        n_queued = 0;
    int        send_gap = 0;
    int        recv_gap = 0;
    int        hold_len = 0;
    int        hold_left = 0;
    bit        no_gaps = 1'b0;
    int        phase_no;
    enc_word_t got_word;
    enc_word_t want;

    dot_stuffing_crlf_encoder DUT (
        .clk       (clk),
        .rst_n     (rst_n),
        .cfg_valid (cfg_valid),
        .cfg_ready (cfg_ready),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data),
        .s_tvalid  (s_tvalid),
        .s_tready  (s_tready),
        .s_tdata   (s_tdata),
        .s_tlast   (s_tlast),
        .m_tvalid  (m_tvalid),
        .m_tready  (m_tready),
        .m_tdata   (m_tdata),
        .m_tlast   (m_tlast),
        .m_tuser   (m_tuser)
    );

    always #6 clk = ~clk;

    function automatic int gap_len();
        int r;
        r = $urandom_range(0, 99);
        if (r < 60)
            return 0;
        if (r < 95)
            return $urandom_range(1, 3);
        return $urandom_range(10, 40);
    endfunction

    function automatic enc_word_t plain_word(input logic [7:0] b);
        enc_word_t w;
        w.byte_val = b;
        w.run_end  = 1'b0;
        w.msg_done = 1'b0;
        return w;
    endfunction

    task automatic clear_msg();
        line_start      = 1'b1;
        body_seen       = 1'b0;
        lines_remaining = '0;
        msg_stopped     = 1'b0;
    endtask

    task automatic encode_byte(input logic [7:0] b, input logic last);
        enc_word_t w[4];
        int        n;
        n = 0;
        if (msg_stopped)
        begin
            if (last)
                clear_msg();
            return;
        end
        if (b == CH_LF)
        begin
            w[0] = plain_word(CH_CR);
            w[1] = plain_word(CH_LF);
            n = 2;
            if (!body_seen)
            begin
                if (line_start)
                begin
                    body_seen = 1'b1;
                    lines_remaining = {1'b0, cfg_limit};
                    if (cfg_enable && cfg_limit == 0)
                        msg_stopped = 1'b1;
                end
            end
            else if (cfg_enable)
            begin
                if (lines_remaining != 0)
                    lines_remaining = lines_remaining - 1'b1;
                if (lines_remaining == 0)
                    msg_stopped = 1'b1;
            end
            line_start = 1'b1;
        end
        else
        begin
            if (b == CH_DOT && line_start)
            begin
                w[n] = plain_word(CH_DOT);
                n++;
            end
            w[n] = plain_word(b);
            n++;
            line_start = 1'b0;
        end
        if (msg_stopped)
        begin
            w[n-1].msg_done = 1'b1;
            if (last)
                clear_msg();
        end
        else if (last)
        begin
            if (!line_start)
            begin
                w[n]   = plain_word(CH_CR);
                w[n+1] = plain_word(CH_LF);
                n += 2;
            end
            w[n-1].msg_done = 1'b1;
            clear_msg();
        end
        w[n-1].run_end = 1'b1;
        for (int i = 0; i < n; i++)
            expected_words.push_back(w[i]);
    endtask

    // input side
    always @(posedge clk)
    begin
        if (rst_n)
        begin
            if (s_tvalid && s_tready)
                encode_byte(s_tdata, s_tlast);
            if (!s_tvalid || s_tready)
            begin
                if (send_gap > 0)
                begin
                    send_gap--;
                    s_tvalid <= 1'b0;
                end
                else if (pending.size() > 0)
                begin
                    raw_byte_t item;
                    item = pending.pop_front();
                    s_tvalid <= 1'b1;
                    s_tdata  <= item.data;
                    s_tlast  <= item.last;
                    send_gap = no_gaps ? 0 : gap_len();
                end
                else
                begin
                    s_tvalid <= 1'b0;
                end
            end
        end
    end

    // output side
    always @(posedge clk)
    begin
        if (rst_n)
        begin
            if (m_tvalid && m_tready)
            begin
                got_word = '{byte_val: m_tdata, run_end: m_tlast, msg_done: m_tuser};
                if (expected_words.size() == 0)
                begin
                    fail_count++;
                    if (fail_count <= 10)
                        $display("unexpected word: byte %h last %b done %b",
                                 m_tdata, m_tlast, m_tuser);
                end
                else
                begin
                    want = expected_words.pop_front();
                    if (got_word !== want)
                    begin
                        fail_count++;
                        if (fail_count <= 10)
                            $display({"mismatch: expected byte %h last %b done %b, ",
                                      "got byte %h last %b done %b"},
                                     want.byte_val, want.run_end, want.msg_done,
                                     m_tdata, m_tlast, m_tuser);
                    end
                end
            end
            if (hold_len > 0)
            begin
                hold_left = hold_len;
                hold_len  = 0;
            end
            if (hold_left > 0)
            begin
                hold_left--;
                m_tready <= 1'b0;
            end
            else if (recv_gap > 0)
            begin
                recv_gap--;
                m_tready <= 1'b0;
            end
            else
            begin
                m_tready <= 1'b1;
                recv_gap = no_gaps ? 0 : gap_len();
            end
        end
    end

    task automatic push_byte(input logic [7:0] b, input logic last);
        raw_byte_t item;
        item.data = b;
        item.last = last;
        pending.push_back(item);
        n_queued++;
    endtask

    task automatic push_text(input string s, input logic end_msg);
        for (int i = 0; i < s.len(); i++)
            push_byte(s[i], end_msg && (i == s.len() - 1));
    endtask

    task automatic wait_drained();
        while (pending.size() != 0 || s_tvalid || expected_words.size() != 0)
            @(negedge clk);
        repeat (12) @(negedge clk);
    endtask

    task automatic cfg_write(input reg_index_t idx, input logic [LIMIT_W-1:0] val);
        @(posedge clk);
        cfg_valid <= 1'b1;
        cfg_index <= idx;
        cfg_data  <= val;
        do
            @(posedge clk);
        while (!cfg_ready);
        cfg_valid <= 1'b0;
        if (idx == REG_LIMIT_ENABLE)
            cfg_enable = val[0];
        else
            cfg_limit = val;
        @(negedge clk);
    endtask

    function automatic logic [LIMIT_W-1:0] pick_limit();
        int r;
        r = $urandom_range(0, 9);
        if (r < 6)
            return LIMIT_W'($urandom_range(0, 4));
        if (r == 6)
            return {LIMIT_W{1'b1}};
        if (r == 7)
            return '0;
        return LIMIT_W'($urandom);
    endfunction

    function automatic logic [7:0] pick_byte();
        int r;
        r = $urandom_range(0, 99);
        if (r < 25)
            return CH_LF;
        if (r < 37)
            return CH_DOT;
        if (r < 45)
            return CH_CR;
        return 8'($urandom_range(0, 255));
    endfunction

    task automatic push_random_message();
        int len;
        bit fin;
        len = $urandom_range(1, 12);
        fin = ($urandom_range(0, 9) != 0);
        for (int i = 0; i < len; i++)
            push_byte(pick_byte(), fin && (i == len - 1));
    endtask

    initial
    begin
        repeat (9) @(posedge clk);
        rst_n <= 1'b1;
        @(negedge clk);

        cfg_write(REG_LIMIT_ENABLE, '0);
        cfg_write(REG_BODY_LINE_LIMIT, '0);
        push_text(".A", 1'b0);
        push_byte(CH_CR, 1'b0);
        push_text("\n\n.x", 1'b1);
        push_byte(8'h00, 1'b1);
        push_byte(8'hFF, 1'b1);
        push_text("\n", 1'b1);
        push_text(".", 1'b1);
        wait_drained();

        // stop at the separator line, then a stop on the message's own last byte
        cfg_write(REG_LIMIT_ENABLE, LIMIT_W'(1));
        push_text("H\n\nzz", 1'b1);
        push_text("\n", 1'b1);
        wait_drained();

        cfg_write(REG_BODY_LINE_LIMIT, {LIMIT_W{1'b1}});
        push_text("\n\n.\n", 1'b1);
        wait_drained();

        // limit switched on while the body is under way
        cfg_write(REG_LIMIT_ENABLE, '0);
        cfg_write(REG_BODY_LINE_LIMIT, LIMIT_W'(1));
        push_text("A\n\nb\nc", 1'b0);
        wait_drained();
        cfg_write(REG_LIMIT_ENABLE, LIMIT_W'(1));
        push_text("\nd\n", 1'b1);

        phase_no = 0;
        while (n_queued < 165)
        begin
            wait_drained();
            cfg_write(REG_LIMIT_ENABLE, LIMIT_W'($urandom_range(0, 1)));
            cfg_write(REG_BODY_LINE_LIMIT, pick_limit());
            no_gaps = ($urandom_range(0, 3) == 0);
            if (phase_no == 2)
            begin
                no_gaps  = 1'b1;
                hold_len = 300;
                repeat (6) push_random_message();
            end
            else
            begin
                repeat ($urandom_range(2, 5)) push_random_message();
            end
            phase_no++;
        end

        wait_drained();
        repeat (20) @(negedge clk);
        if (fail_count == 0 && expected_words.size() == 0)
            $display("dot_stuffing_crlf_encoder test passed");
        else
            $display("dot_stuffing_crlf_encoder test failed");
        $finish;
    end

    initial
    begin
        #2_400_000;
        $display("dot_stuffing_crlf_encoder test failed");
        $finish;
    end

endmodule
